/* rtl/size_class_bitmap_allocator_unit_macros.svh */
// Assertion helpers used by the top-level unit, which checks itself.
// Each macro expands to one labeled concurrent assertion on clk, muted during reset.
`ifndef SIZE_CLASS_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`define SIZE_CLASS_BITMAP_ALLOCATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCBM_CHECK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCBM_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/scbm_pkg.sv */
package scbm_pkg;

	localparam int unsigned LEVELS = 4;
	localparam int unsigned LVL_W = $clog2(LEVELS);
	localparam int unsigned BMAP_W = 64;
	localparam int unsigned IDX_W = $clog2(BMAP_W);
	localparam int unsigned CNT_W = IDX_W + 1;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned SIZE_W = DATA_W + 1;

	localparam int unsigned A_BLOCKS_DEF = 64;
	localparam int unsigned B_BLOCKS_DEF = 32;
	localparam int unsigned C_BLOCKS_DEF = 16;
	localparam int unsigned D_BLOCKS_DEF = 8;
	localparam int unsigned BASE_SHIFT_DEF = 12;
	localparam int unsigned ADDR_WIDTH_DEF = 32;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [1:0] CFG_POOL_A = 2'd0;
	localparam logic [1:0] CFG_POOL_B = 2'd1;
	localparam logic [1:0] CFG_POOL_C = 2'd2;
	localparam logic [1:0] CFG_POOL_D = 2'd3;

	typedef enum logic [2:0] {
		ST_ALLOC = 3'd0,
		ST_FREED = 3'd1,
		ST_NOFIT = 3'd2,
		ST_OUTSIDE = 3'd3,
		ST_DOUBLE = 3'd4,
		ST_IGNORED = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		KIND_IGNORE,
		KIND_ALLOC,
		KIND_RELEASE
	} kind_t;

	// One classified item. For an allocation the mask marks the pools whose block
	// size covers the request; for a release it marks the pools whose range holds
	// the address, and idx gives the block index within each of them.
	typedef struct packed {
		kind_t kind;
		logic [LEVELS-1:0] hit_mask;
		logic [LEVELS-1:0][IDX_W-1:0] idx;
	} entry_t;

	typedef struct packed {
		status_t status;
		logic [DATA_W-1:0] block_addr;
		logic [LVL_W-1:0] level;
		logic [IDX_W-1:0] number;
		logic [CNT_W-1:0] free_blocks;
		logic [DATA_W-1:0] alloc_total;
		logic [DATA_W-1:0] pool_hits;
	} result_t;

	function automatic int unsigned shift_of(input int unsigned base_shift,
		input int unsigned lvl);
		return base_shift + 2 * lvl;
	endfunction

	function automatic logic [LVL_W-1:0] lowest_level(input logic [LEVELS-1:0] m);
		logic [LVL_W-1:0] r;
		r = '0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (m[i]) r = LVL_W'(i);
		end
		return r;
	endfunction

	function automatic logic [IDX_W-1:0] lowest_set_idx(input logic [BMAP_W-1:0] v);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = BMAP_W - 1; i >= 0; i--) begin
			if (v[i]) r = IDX_W'(i);
		end
		return r;
	endfunction

endpackage

/* rtl/scbm_front.sv */
module scbm_front #(
	parameter int unsigned A_BLOCKS = scbm_pkg::A_BLOCKS_DEF,
	parameter int unsigned B_BLOCKS = scbm_pkg::B_BLOCKS_DEF,
	parameter int unsigned C_BLOCKS = scbm_pkg::C_BLOCKS_DEF,
	parameter int unsigned D_BLOCKS = scbm_pkg::D_BLOCKS_DEF,
	parameter int unsigned BASE_SHIFT = scbm_pkg::BASE_SHIFT_DEF,
	parameter int unsigned ADDR_WIDTH = scbm_pkg::ADDR_WIDTH_DEF
) (
	input logic op,
	input logic [scbm_pkg::DATA_W-1:0] req_size,
	input logic [scbm_pkg::DATA_W-1:0] release_addr,
	input logic [scbm_pkg::LEVELS-1:0][scbm_pkg::DATA_W-1:0] base,
	output scbm_pkg::entry_t entry
);
	import scbm_pkg::*;

	localparam int unsigned AW = ADDR_WIDTH;
	// Range ends are compared without wrapping, so the sum gets room to grow.
	localparam int unsigned SW = ((AW > SIZE_W) ? AW : SIZE_W) + 1;
	localparam int unsigned CNT [LEVELS] = '{A_BLOCKS, B_BLOCKS, C_BLOCKS, D_BLOCKS};

	logic [AW-1:0] addr_w;
	logic [AW-1:0] base_w [LEVELS];
	logic [AW-1:0] diff [LEVELS];
	logic [SW-1:0] lo [LEVELS];
	logic [SW-1:0] hi [LEVELS];
	logic [LEVELS-1:0] fit;
	logic [LEVELS-1:0] in_rng;
	logic [LEVELS-1:0][IDX_W-1:0] idx_l;

	always_comb begin
		addr_w = AW'(release_addr);
		for (int l = 0; l < LEVELS; l++) begin
			base_w[l] = AW'(base[l]);
			lo[l] = SW'(base_w[l]);
			hi[l] = lo[l] + (SW'(CNT[l]) << shift_of(BASE_SHIFT, l));
			fit[l] = {1'b0, req_size} <= (SIZE_W'(1) << shift_of(BASE_SHIFT, l));
			in_rng[l] = (SW'(addr_w) >= lo[l]) && (SW'(addr_w) < hi[l]);
			diff[l] = addr_w - base_w[l];
			idx_l[l] = IDX_W'(diff[l] >> shift_of(BASE_SHIFT, l));
		end
	end

	always_comb begin
		entry.kind = KIND_IGNORE;
		entry.hit_mask = '0;
		entry.idx = '0;
		if (op == OP_ALLOC) begin
			if (req_size != '0) begin
				entry.kind = KIND_ALLOC;
				entry.hit_mask = fit;
			end
		end else if (addr_w != '0) begin
			entry.kind = KIND_RELEASE;
			entry.hit_mask = in_rng;
			entry.idx = idx_l;
		end
	end

endmodule

/* rtl/scbm_queue.sv */
module scbm_queue (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input scbm_pkg::entry_t push_data,
	output logic pop_valid,
	input logic pop_ready,
	output scbm_pkg::entry_t pop_data
);
	import scbm_pkg::*;

	entry_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0] count_q;
	logic push;
	logic pop;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign push_ready = count_q != (QPTR_W + 1)'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_data = mem_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

/* rtl/scbm_back.sv */
module scbm_back #(
	parameter int unsigned A_BLOCKS = scbm_pkg::A_BLOCKS_DEF,
	parameter int unsigned B_BLOCKS = scbm_pkg::B_BLOCKS_DEF,
	parameter int unsigned C_BLOCKS = scbm_pkg::C_BLOCKS_DEF,
	parameter int unsigned D_BLOCKS = scbm_pkg::D_BLOCKS_DEF,
	parameter int unsigned BASE_SHIFT = scbm_pkg::BASE_SHIFT_DEF,
	parameter int unsigned ADDR_WIDTH = scbm_pkg::ADDR_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	output logic head_ready,
	input scbm_pkg::entry_t head,
	input logic [scbm_pkg::LEVELS-1:0][scbm_pkg::DATA_W-1:0] base,
	output logic res_valid,
	input logic res_ready,
	output scbm_pkg::result_t res
);
	import scbm_pkg::*;

	localparam int unsigned AW = ADDR_WIDTH;
	localparam int unsigned CNT [LEVELS] = '{A_BLOCKS, B_BLOCKS, C_BLOCKS, D_BLOCKS};

	logic [BMAP_W-1:0] occ_q [LEVELS];
	logic [CNT_W-1:0] free_q [LEVELS];
	logic [DATA_W-1:0] req_cnt_q;
	logic [DATA_W-1:0] hit_cnt_q;
	logic res_valid_q;
	result_t res_q;

	logic [BMAP_W-1:0] used_m [LEVELS];
	logic [BMAP_W-1:0] clear_m [LEVELS];
	logic [LEVELS-1:0] cand;
	logic [LVL_W-1:0] lvl;
	logic [BMAP_W-1:0] clear_sel;
	logic [BMAP_W-1:0] occ_sel;
	logic [CNT_W-1:0] free_sel;
	logic [CNT_W-1:0] cnt_sel;
	logic [AW-1:0] base_sel;
	logic [AW-1:0] offset;
	logic [AW-1:0] addr_sum;
	logic [IDX_W-1:0] bit_idx;
	logic [BMAP_W-1:0] occ_new;
	logic [CNT_W-1:0] free_new;
	logic [DATA_W-1:0] req_d;
	logic [DATA_W-1:0] hit_d;
	logic upd;
	result_t res_d;
	logic fire;

	assign head_ready = !res_valid_q || res_ready;
	assign fire = head_valid && head_ready;
	assign res_valid = res_valid_q;
	assign res = res_q;

	// Pick the pool, then the block, from the selected pool only.
	always_comb begin
		for (int l = 0; l < LEVELS; l++) begin
			for (int i = 0; i < BMAP_W; i++) begin
				used_m[l][i] = i < CNT[l];
			end
			clear_m[l] = ~occ_q[l] & used_m[l];
			cand[l] = head.hit_mask[l] && (free_q[l] != '0) && (|clear_m[l]);
		end
		lvl = (head.kind == KIND_ALLOC) ? lowest_level(cand) : lowest_level(head.hit_mask);
		clear_sel = '0;
		occ_sel = '0;
		free_sel = '0;
		cnt_sel = '0;
		base_sel = '0;
		for (int l = 0; l < LEVELS; l++) begin
			if (lvl == LVL_W'(l)) begin
				clear_sel = clear_m[l];
				occ_sel = occ_q[l];
				free_sel = free_q[l];
				cnt_sel = CNT_W'(CNT[l]);
				base_sel = AW'(base[l]);
			end
		end
		bit_idx = (head.kind == KIND_ALLOC) ? lowest_set_idx(clear_sel) : head.idx[lvl];
		offset = '0;
		for (int l = 0; l < LEVELS; l++) begin
			if (lvl == LVL_W'(l)) offset = AW'(bit_idx) << shift_of(BASE_SHIFT, l);
		end
		addr_sum = base_sel + offset;
	end

	always_comb begin
		occ_new = occ_sel;
		free_new = free_sel;
		req_d = req_cnt_q;
		hit_d = hit_cnt_q;
		upd = 1'b0;
		res_d.status = ST_IGNORED;
		res_d.block_addr = '0;
		res_d.level = '0;
		res_d.number = '0;
		res_d.free_blocks = '0;
		unique case (head.kind)
			KIND_ALLOC: begin
				req_d = req_cnt_q + 1'b1;
				res_d.status = ST_NOFIT;
				if (|cand) begin
					occ_new[bit_idx] = 1'b1;
					free_new = free_sel - 1'b1;
					hit_d = hit_cnt_q + 1'b1;
					upd = 1'b1;
					res_d.status = ST_ALLOC;
					res_d.block_addr = DATA_W'(addr_sum);
					res_d.level = lvl;
					res_d.number = bit_idx;
					res_d.free_blocks = free_new;
				end
			end
			KIND_RELEASE: begin
				res_d.status = ST_OUTSIDE;
				if (|head.hit_mask) begin
					if (!occ_sel[bit_idx]) begin
						res_d.status = ST_DOUBLE;
					end else begin
						occ_new[bit_idx] = 1'b0;
						if (free_sel < cnt_sel) free_new = free_sel + 1'b1;
						upd = 1'b1;
						res_d.status = ST_FREED;
					end
					res_d.level = lvl;
					res_d.number = bit_idx;
					res_d.free_blocks = free_new;
				end
			end
			default: begin
				upd = 1'b0;
			end
		endcase
		res_d.alloc_total = req_d;
		res_d.pool_hits = hit_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LEVELS; l++) begin
				occ_q[l] <= '0;
				free_q[l] <= CNT_W'(CNT[l]);
			end
			req_cnt_q <= '0;
			hit_cnt_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				for (int l = 0; l < LEVELS; l++) begin
					if (upd && (lvl == LVL_W'(l))) begin
						occ_q[l] <= occ_new;
						free_q[l] <= free_new;
					end
				end
				req_cnt_q <= req_d;
				hit_cnt_q <= hit_d;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) res_q <= res_d;
	end

endmodule

/* rtl/size_class_bitmap_allocator_unit.sv */
// Channel  | Direction | Handshake              | Carries
// ---------+-----------+------------------------+-------------------------------------------
// cfg      | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data (pool base addresses)
// in       | in        | in_valid / in_ready    | op, req_size, release_addr
// out      | out       | out_valid / out_ready  | status, block_addr, pool_level, block_number,
//          |           |                        | pool_free_blocks, alloc_total, pool_hits
//
// Throughput is one item per cycle while out_ready stays high; an accepted item is first
// written into the queue, and its result is registered in the back end, which does the
// bitmap update with its find-first-clear over up to 64 bits.
// A two-item queue sits between the classifier and the back end, so in_ready drops only
// when that queue is full, which happens only while out_ready is held low.
// Reset clears every bitmap, sets each free count to its pool's block count, zeroes the
// counters and the pool bases; no clearing pass is needed, and cfg_ready is always high.
`include "size_class_bitmap_allocator_unit_macros.svh"

module size_class_bitmap_allocator_unit #(
	parameter int unsigned A_BLOCKS = scbm_pkg::A_BLOCKS_DEF,
	parameter int unsigned B_BLOCKS = scbm_pkg::B_BLOCKS_DEF,
	parameter int unsigned C_BLOCKS = scbm_pkg::C_BLOCKS_DEF,
	parameter int unsigned D_BLOCKS = scbm_pkg::D_BLOCKS_DEF,
	parameter int unsigned BASE_SHIFT = scbm_pkg::BASE_SHIFT_DEF,
	parameter int unsigned ADDR_WIDTH = scbm_pkg::ADDR_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [scbm_pkg::DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic op,
	input logic [scbm_pkg::DATA_W-1:0] req_size,
	input logic [scbm_pkg::DATA_W-1:0] release_addr,
	output logic out_valid,
	input logic out_ready,
	output logic [2:0] status,
	output logic [scbm_pkg::DATA_W-1:0] block_addr,
	output logic [scbm_pkg::LVL_W-1:0] pool_level,
	output logic [scbm_pkg::IDX_W-1:0] block_number,
	output logic [scbm_pkg::CNT_W-1:0] pool_free_blocks,
	output logic [scbm_pkg::DATA_W-1:0] alloc_total,
	output logic [scbm_pkg::DATA_W-1:0] pool_hits
);
	import scbm_pkg::*;

	// Pool base registers. Software is to write them only while the block is idle (the block
	// itself does not enforce this), so the classifier and the back end may both read them directly.
	logic [LEVELS-1:0][DATA_W-1:0] base_q;

	entry_t front_entry;
	entry_t head;
	logic head_valid;
	logic head_ready;
	logic q_pop;
	result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_POOL_A: base_q[0] <= cfg_data;
				CFG_POOL_B: base_q[1] <= cfg_data;
				CFG_POOL_C: base_q[2] <= cfg_data;
				CFG_POOL_D: base_q[3] <= cfg_data;
			endcase
		end
	end

	// The front end classifies each item: which pools fit an allocation, or which pool
	// range holds a released address and at which block index. It holds no state, so the
	// classification is written straight into the queue when the item is accepted.
	scbm_front #(
		.A_BLOCKS(A_BLOCKS),
		.B_BLOCKS(B_BLOCKS),
		.C_BLOCKS(C_BLOCKS),
		.D_BLOCKS(D_BLOCKS),
		.BASE_SHIFT(BASE_SHIFT),
		.ADDR_WIDTH(ADDR_WIDTH)
	) u_front (
		.op(op),
		.req_size(req_size),
		.release_addr(release_addr),
		.base(base_q),
		.entry(front_entry)
	);

	scbm_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(in_valid),
		.push_ready(in_ready),
		.push_data(front_entry),
		.pop_valid(head_valid),
		.pop_ready(head_ready),
		.pop_data(head)
	);

	// The back end owns the bitmaps, the free counts and the counters. It retires one
	// queued item per cycle whenever its result register is empty or being drained.
	scbm_back #(
		.A_BLOCKS(A_BLOCKS),
		.B_BLOCKS(B_BLOCKS),
		.C_BLOCKS(C_BLOCKS),
		.D_BLOCKS(D_BLOCKS),
		.BASE_SHIFT(BASE_SHIFT),
		.ADDR_WIDTH(ADDR_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_ready(head_ready),
		.head(head),
		.base(base_q),
		.res_valid(out_valid),
		.res_ready(out_ready),
		.res(res)
	);

	assign q_pop = head_valid && head_ready;

	assign status = res.status;
	assign block_addr = res.block_addr;
	assign pool_level = res.level;
	assign block_number = res.number;
	assign pool_free_blocks = res.free_blocks;
	assign alloc_total = res.alloc_total;
	assign pool_hits = res.pool_hits;

	// Every item taken from the queue must show up as a result in the next cycle.
	`SCBM_CHECK_NEXT(a_pop_gives_result, q_pop, out_valid, "queued item produced no result")

	// Results that touch no pool carry no pool details.
	`SCBM_CHECK(a_no_pool_fields, out_valid && (status == ST_NOFIT || status == ST_OUTSIDE || status == ST_IGNORED), (block_addr == '0) && (pool_level == '0) && (block_number == '0) && (pool_free_blocks == '0), "pool fields set on a result that used no pool")

	// A successful release always leaves at least one free block in its pool.
	`SCBM_CHECK(a_freed_count, out_valid && (status == ST_FREED), pool_free_blocks != '0, "release left its pool with no free block")

endmodule
